FILE: design/modbus_rtu_slave_responder_defines.svh
// assertion macros shared by the modbus rtu slave responder design files
// expects aclk and aresetn in the scope of every use
`ifndef MODBUS_RTU_SLAVE_RESPONDER_DEFINES_SVH
`define MODBUS_RTU_SLAVE_RESPONDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MRS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define MRS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MRS_ASSERT(label, prop)
`define MRS_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: design/mrs_pkg.sv
// types, constants and the crc-16 step shared by the modbus rtu slave responder
// no dependencies
package mrs_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_ADDR = 3'd1;
    localparam logic [2:0] STAT_BAD_FUNC = 3'd2;
    localparam logic [2:0] STAT_BAD_CRC  = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT  = 3'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_FUNC       = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [7:0] REPLY_BYTE_COUNT = 8'd2;

    // reply byte positions
    localparam logic [2:0] RPOS_FUNC   = 3'd1;
    localparam logic [2:0] RPOS_COUNT  = 3'd2;
    localparam logic [2:0] RPOS_P_HI   = 3'd3;
    localparam logic [2:0] RPOS_P_LO   = 3'd4;
    localparam logic [2:0] RPOS_CRC_LO = 3'd5;
    localparam logic [2:0] RPOS_CRC_HI = 3'd6;

    typedef struct packed {
        logic        action;
        logic [7:0]  rx_byte;
        logic [15:0] pressure_sample;
    } in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [2:0] status;
    } out_t;

    // one classified frame event handed from front to back
    typedef struct packed {
        logic        is_reply;
        logic [2:0]  status;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] pressure;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: design/mrs_front.sv
// front end: frame collection, running crc, idle timeout and frame checks
// depends on mrs_pkg
module mrs_front #(
    parameter int FRAME_LEN = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  mrs_pkg::in_t  in_data,
    input  logic [7:0]    cfg_slave_address,
    input  logic [7:0]    cfg_accepted_function,
    input  logic [15:0]   cfg_timeout_ticks,
    output logic          push,
    output mrs_pkg::cmd_t push_data
);
    import mrs_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      idle_reg, idle_next;
    logic [15:0]      idle_inc;
    // only the bytes that the checks look at are kept
    logic [7:0]       addr_b_reg, addr_b_next;
    logic [7:0]       func_b_reg, func_b_next;
    logic [7:0]       crclo_b_reg, crclo_b_next;

    always_comb begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        idle_next    = idle_reg;
        addr_b_next  = addr_b_reg;
        func_b_next  = func_b_reg;
        crclo_b_next = crclo_b_reg;
        push         = 1'b0;
        push_data    = '0;
        idle_inc     = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
        if (in_fire) begin
            if (in_data.action) begin
                if (count_reg != '0) begin
                    idle_next = idle_inc;
                    if (idle_inc > cfg_timeout_ticks) begin
                        count_next       = '0;
                        crc_next         = CRC_INIT;
                        idle_next        = '0;
                        push             = 1'b1;
                        push_data.status = STAT_TIMEOUT;
                    end
                end
            end else begin
                idle_next = '0;
                if (count_reg == '0) begin
                    addr_b_next = in_data.rx_byte;
                end
                if (count_reg == CNT_W'(1)) begin
                    func_b_next = in_data.rx_byte;
                end
                if (count_reg == CNT_W'(FRAME_LEN - 2)) begin
                    crclo_b_next = in_data.rx_byte;
                end
                if (count_reg < CNT_W'(FRAME_LEN - 2)) begin
                    crc_next = crc_byte(crc_reg, in_data.rx_byte);
                end
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(FRAME_LEN - 1)) begin
                    // frame complete, the current byte is the crc high byte
                    count_next         = '0;
                    crc_next           = CRC_INIT;
                    push               = 1'b1;
                    push_data.addr     = addr_b_reg;
                    push_data.func     = func_b_reg;
                    push_data.pressure = in_data.pressure_sample;
                    if (addr_b_reg != cfg_slave_address) begin
                        push_data.status = STAT_BAD_ADDR;
                    end else if (func_b_reg != cfg_accepted_function) begin
                        push_data.status = STAT_BAD_FUNC;
                    end else if (crclo_b_reg != crc_reg[7:0] ||
                                 in_data.rx_byte != crc_reg[15:8]) begin
                        push_data.status = STAT_BAD_CRC;
                    end else begin
                        push_data.status   = STAT_OK;
                        push_data.is_reply = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            idle_reg  <= '0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            idle_reg  <= idle_next;
        end
        addr_b_reg  <= addr_b_next;
        func_b_reg  <= func_b_next;
        crclo_b_reg <= crclo_b_next;
    end

endmodule

FILE: design/mrs_queue.sv
// short command queue between front and back ends
// depends on mrs_pkg; DEPTH is a power of two
`include "modbus_rtu_slave_responder_defines.svh"
module mrs_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mrs_pkg::cmd_t push_data,
    input  logic          pop,
    output mrs_pkg::cmd_t head,
    output logic          not_empty,
    output logic          full
);
    import mrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head      = slots_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
        if (push) begin
            slots_reg[wptr_reg] <= push_data;
        end
    end

    `MRS_ASSERT(a_no_overflow, push |-> (!full || pop))
    `MRS_ASSERT(a_no_underflow, pop |-> not_empty)
    `MRS_ASSERT_NEXT(a_push_fills, push && !pop, not_empty)

endmodule

FILE: design/mrs_back.sv
// back end: turns commands into status beats or the seven-byte reply
// depends on mrs_pkg
`include "modbus_rtu_slave_responder_defines.svh"
module mrs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  mrs_pkg::cmd_t cmd_head,
    output logic          cmd_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mrs_pkg::out_t m_data
);
    import mrs_pkg::*;

    typedef enum logic {S_IDLE, S_REPLY} state_t;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;
    cmd_t        cmd_reg, cmd_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sel_byte;
    logic        load;

    assign load    = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (idx_reg)
            RPOS_FUNC:   sel_byte = cmd_reg.func;
            RPOS_COUNT:  sel_byte = REPLY_BYTE_COUNT;
            RPOS_P_HI:   sel_byte = cmd_reg.pressure[15:8];
            RPOS_P_LO:   sel_byte = cmd_reg.pressure[7:0];
            RPOS_CRC_LO: sel_byte = crc_reg[7:0];
            RPOS_CRC_HI: sel_byte = crc_reg[15:8];
            default:     sel_byte = cmd_reg.addr;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        cmd_pop        = 1'b0;
        if (load) begin
            out_valid_next = 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_pop        = 1'b1;
                        out_valid_next = 1'b1;
                        if (cmd_head.is_reply) begin
                            out_next   = '{tx_byte: cmd_head.addr, last: 1'b0,
                                           status: STAT_OK};
                            crc_next   = crc_byte(CRC_INIT, cmd_head.addr);
                            cmd_next   = cmd_head;
                            idx_next   = RPOS_FUNC;
                            state_next = S_REPLY;
                        end else begin
                            out_next = '{tx_byte: 8'h00, last: 1'b1,
                                         status: cmd_head.status};
                        end
                    end
                end
                S_REPLY: begin
                    out_valid_next = 1'b1;
                    out_next = '{tx_byte: sel_byte, last: (idx_reg == RPOS_CRC_HI),
                                 status: STAT_OK};
                    if (idx_reg < RPOS_CRC_LO) begin
                        crc_next = crc_byte(crc_reg, sel_byte);
                    end
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == RPOS_CRC_HI) begin
                        state_next = S_IDLE;
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        crc_reg <= crc_next;
    end

    `MRS_ASSERT(a_status_is_last, out_valid_reg |-> (out_reg.status == STAT_OK || out_reg.last))
    `MRS_ASSERT(a_reply_idx_range,
        state_reg == S_REPLY |-> (idx_reg >= RPOS_FUNC && idx_reg <= RPOS_CRC_HI))
    `MRS_ASSERT(a_last_reply_ends,
        (out_valid_reg && out_reg.status == STAT_OK && out_reg.last) |-> state_reg == S_IDLE)
    `MRS_ASSERT_NEXT(a_no_pop_in_reply, state_reg == S_REPLY && !load, $stable(idx_reg))

endmodule

FILE: design/modbus_rtu_slave_responder.sv
// top level of the modbus rtu slave responder: config registers, front, queue, back
// depends on mrs_pkg, mrs_front, mrs_queue, mrs_back
// A beat on s_ is either a received byte (action 0) or one time tick (action 1). The block
// takes one beat per clock; s_ready drops only while the two-entry command queue is full.
// Bytes are gathered into a frame of FRAME_LEN bytes while the crc-16 (reflected 0xA001,
// start 0xFFFF) runs one byte per cycle in the front end; when the last byte arrives the
// address, function code and crc (low byte first) are checked in that order in the same
// cycle. A good frame yields seven m_ beats: address, function, count 2, pressure high,
// pressure low, crc low, crc high, the last one flagged; a bad frame or a timed-out partial
// frame yields a single status beat with last set. The back end emits one beat per cycle,
// unless m_ready holds it, from a registered output stage; the reply crc is built one byte
// per emitted beat. Ticks only count while a partial frame is pending, and a frame is
// dropped once the tick count passes timeout_ticks. Registers sit at apb byte addresses
// 0 (slave address), 4 (accepted function) and 8 (timeout ticks) and should only be
// written while the block is idle.
module modbus_rtu_slave_responder #(
    parameter int FRAME_LEN = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input beats
    input  logic          s_valid,
    output logic          s_ready,
    input  mrs_pkg::in_t  s_data,
    // result beats
    output logic          m_valid,
    input  logic          m_ready,
    output mrs_pkg::out_t m_data,
    // config port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mrs_pkg::*;

    logic [7:0]  slave_address_reg;
    logic [7:0]  accepted_function_reg;
    logic [15:0] timeout_ticks_reg;
    logic        cfg_write;
    logic [1:0]  reg_idx;

    logic        in_fire;
    logic        push;
    cmd_t        push_data;
    logic        pop;
    cmd_t        head;
    logic        q_not_empty;
    logic        q_full;

    // register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg     <= 8'd2;
            accepted_function_reg <= 8'd3;
            timeout_ticks_reg     <= 16'd10;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SLAVE_ADDR: slave_address_reg     <= pwdata[7:0];
                REG_FUNC:       accepted_function_reg <= pwdata[7:0];
                REG_TIMEOUT:    timeout_ticks_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SLAVE_ADDR: prdata = {24'h0, slave_address_reg};
            REG_FUNC:       prdata = {24'h0, accepted_function_reg};
            REG_TIMEOUT:    prdata = {16'h0, timeout_ticks_reg};
            default:        prdata = '0;
        endcase
    end

    // input side stalls only on a full queue
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    mrs_front #(
        .FRAME_LEN(FRAME_LEN)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .in_fire              (in_fire),
        .in_data              (s_data),
        .cfg_slave_address    (slave_address_reg),
        .cfg_accepted_function(accepted_function_reg),
        .cfg_timeout_ticks    (timeout_ticks_reg),
        .push                 (push),
        .push_data            (push_data)
    );

    mrs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .not_empty(q_not_empty),
        .full     (q_full)
    );

    mrs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_not_empty),
        .cmd_head (head),
        .cmd_pop  (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
